@@ sv/lfd_pkg.sv @@
package lfd_pkg;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_SET_TARGET = 3'd1,
        CMD_SET_ACTUAL = 3'd2,
        CMD_TOGGLE     = 3'd3,
        CMD_DIM_START  = 3'd4,
        CMD_DIM_END    = 3'd5,
        CMD_TIMER      = 3'd6,
        CMD_NONE       = 3'd7
    } cmd_t;

    localparam logic [2:0] REG_MAX_LEVEL     = 3'd0;
    localparam logic [2:0] REG_DEFAULT_LEVEL = 3'd1;
    localparam logic [2:0] REG_DEFAULT_OFF   = 3'd2;
    localparam logic [2:0] REG_FADE_INTERVAL = 3'd3;
    localparam logic [2:0] REG_FADE_STEP     = 3'd4;

    localparam int GAMMA_INDEX_BITS = 10;
    localparam int DIV_STEPS        = 8 + GAMMA_INDEX_BITS;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture request and run command logic
        logic div_start; // start the normalising divide
        logic div_step;  // one restoring divide step
        logic finish;    // take gamma duty, update timer
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_gamma; // written level strictly between off and full
    } dp_status_t;

endpackage

@@ sv/led_fade_dimmer_with_gamma.sv @@
// One LED dimmer channel with fade ramp, dimming sweep, auto-off timer and
// gamma correction.
// Request channel: in_valid/in_stall with command, now_ms, level_value and
// timer_seconds. A request is taken when in_valid is high and in_stall low.
// Result channel: out_valid/out_stall, one result per request carrying
// duty_written, duty, target_level, actual_level and timer_running.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no request is in flight.
// Flow: a taken request enters S_EVAL; when no gamma lookup is needed it goes
// on to S_OUT, where out_valid rises. When the level needs the normalising
// divide it first passes S_DIV, where the restoring divider yields one
// quotient bit a cycle (8 + index bits), and then S_DONE.
// One request at a time; in_stall is high from acceptance until the result
// has been taken.
// While out_stall is high the result holds and no new request is accepted.
// Reset restores the register defaults and clears levels, timer and modes.
module led_fade_dimmer_with_gamma (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [31:0] now_ms,
    input  logic [7:0]  level_value,
    input  logic [15:0] timer_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        duty_written,
    output logic [7:0]  duty,
    output logic [7:0]  target_level,
    output logic [7:0]  actual_level,
    output logic        timer_running,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lfd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lfd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
    );

    lfd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .command(command), .now_ms(now_ms), .level_value(level_value),
        .timer_seconds(timer_seconds), .duty_written(duty_written), .duty(duty),
        .target_level(target_level), .actual_level(actual_level),
        .timer_running(timer_running)
    );

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while result pending");

    a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.finish}))
        else $error("controller commands overlap");

    a_no_write_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !duty_written) |=> (!out_valid || $stable(duty) || !out_stall))
        else $error("duty changed while result stalled");
endmodule

@@ sv/lfd_ctrl.sv @@
module lfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output lfd_pkg::dp_cmd_t    cmd,
    input  lfd_pkg::dp_status_t status
);
    import lfd_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DIV, S_DONE, S_OUT} state_t;

    state_t     state_reg;
    logic [4:0] cnt_reg;
    logic       out_valid_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.div_start = (state_reg == S_EVAL) && status.need_gamma;
        cmd.div_step  = (state_reg == S_DIV);
        cmd.finish    = (state_reg == S_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_EVAL;
                S_EVAL:
                    if (status.need_gamma)
                    begin
                        cnt_reg   <= 5'(DIV_STEPS - 1);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                S_DIV:
                    if (cnt_reg == '0)
                        state_reg <= S_DONE;
                    else
                        cnt_reg <= cnt_reg - 5'd1;
                S_DONE:
                begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/lfd_datapath.sv @@
module lfd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lfd_pkg::dp_cmd_t    cmd,
    output lfd_pkg::dp_status_t status,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [2:0]          command,
    input  logic [31:0]         now_ms,
    input  logic [7:0]          level_value,
    input  logic [15:0]         timer_seconds,
    output logic                duty_written,
    output logic [7:0]          duty,
    output logic [7:0]          target_level,
    output logic [7:0]          actual_level,
    output logic                timer_running
);
    import lfd_pkg::*;

    localparam int B  = GAMMA_INDEX_BITS;
    localparam int QN = 8 + B;
    localparam int ROM_DEPTH = 1 << B;

    // Gamma table, built exactly at elaboration: the largest y with
    // (2y-1)^5 * 2^(14B) <= 510^5 * q^14
    function automatic logic [7:0] gamma_entry(input int q);
        logic [255:0] rhs;
        logic [255:0] lhs;
        int lo, hi, mid;
        rhs = 256'd1;
        repeat (5) rhs = rhs * 256'd510;
        repeat (14) rhs = rhs * 256'(q);
        lo = 0;
        hi = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            lhs = 256'd1;
            repeat (5) lhs = lhs * 256'(2 * mid - 1);
            lhs = lhs << (14 * B);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return 8'(lo);
    endfunction

    logic [7:0] gamma_rom [ROM_DEPTH];
    for (genvar g = 0; g < ROM_DEPTH; g++)
    begin : g_rom
        assign gamma_rom[g] = gamma_entry(g);
    end

    logic [7:0]  max_reg, deflvl_reg, step_reg;
    logic [15:0] defoff_reg, interval_reg;
    logic [7:0]  target_reg, actual_reg, duty_reg;
    logic [31:0] deadline_reg, last_tick_reg, now_reg;
    logic        tvalid_reg, dim_on_reg, dim_up_reg, wrote_reg, gamma_reg;

    logic [QN-1:0] quo_reg;
    logic [8:0]    rem_reg;

    logic [7:0]  scale;
    logic [7:0]  t_next, a_next;
    logic [31:0] dl_next;
    logic        tv_next, wrote_next, dim_on_next, dim_up_next, tick_ok, expired;
    logic [8:0]  rem_sh;
    logic [8:0]  step_sum;

    assign scale = (max_reg == 8'd0) ? 8'd100 : max_reg;

    always_comb
    begin
        t_next      = target_reg;
        a_next      = actual_reg;
        dl_next     = deadline_reg;
        tv_next     = tvalid_reg;
        dim_on_next = dim_on_reg;
        dim_up_next = dim_up_reg;
        wrote_next  = 1'b0;
        tick_ok     = (now_ms - last_tick_reg) >= {16'd0, interval_reg};
        expired     = tvalid_reg && !(now_ms - deadline_reg >= 32'h8000_0000);
        step_sum    = '0;
        case (cmd_t'(command))
            CMD_TICK:
                if (tick_ok)
                begin
                    if (expired)
                    begin
                        t_next  = '0;
                        tv_next = 1'b0;
                        dl_next = '0;
                    end
                    if (dim_on_reg)
                    begin
                        if (dim_up_reg)
                            t_next = (t_next >= max_reg) ? max_reg : t_next + 8'd1;
                        else
                            t_next = (t_next == 8'd0) ? 8'd0 : t_next - 8'd1;
                        a_next     = t_next;
                        wrote_next = 1'b1;
                    end
                    else if (actual_reg != t_next)
                    begin
                        wrote_next = 1'b1;
                        if (actual_reg < t_next)
                        begin
                            step_sum = {1'b0, actual_reg} + {1'b0, step_reg};
                            a_next = (step_sum < {1'b0, t_next}) ? step_sum[7:0] : t_next;
                        end
                        else
                        begin
                            step_sum = {1'b0, actual_reg} - {1'b0, step_reg};
                            a_next = (!step_sum[8] && step_sum[7:0] > t_next) ?
                                     step_sum[7:0] : t_next;
                        end
                    end
                end
            CMD_SET_TARGET: t_next = level_value;
            CMD_SET_ACTUAL: a_next = level_value;
            CMD_TOGGLE:
                if (target_reg != 8'd0)
                begin
                    t_next  = '0;
                    tv_next = 1'b0;
                    dl_next = '0;
                end
                else
                    t_next = deflvl_reg;
            CMD_DIM_START:
            begin
                dim_up_next = !dim_up_reg;
                dim_on_next = 1'b1;
            end
            CMD_DIM_END: dim_on_next = 1'b0;
            CMD_TIMER:
            begin
                tv_next = (timer_seconds != 16'd0);
                dl_next = (timer_seconds != 16'd0) ?
                          now_ms + 32'(timer_seconds) * 32'd1000 : 32'd0;
            end
            default: ;
        endcase
    end

    assign status.need_gamma = gamma_reg;
    assign rem_sh = {rem_reg[7:0], quo_reg[QN-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 8'd100; deflvl_reg <= 8'd100; defoff_reg <= '0;
            interval_reg <= 16'd15; step_reg <= 8'd2;
            target_reg <= '0; actual_reg <= '0; duty_reg <= '0;
            deadline_reg <= '0; last_tick_reg <= '0; tvalid_reg <= 1'b0;
            dim_on_reg <= 1'b0; dim_up_reg <= 1'b0; wrote_reg <= 1'b0;
            gamma_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MAX_LEVEL:     max_reg      <= cfg_data[7:0];
                    REG_DEFAULT_LEVEL: deflvl_reg   <= cfg_data[7:0];
                    REG_DEFAULT_OFF:   defoff_reg   <= cfg_data;
                    REG_FADE_INTERVAL: interval_reg <= cfg_data;
                    REG_FADE_STEP:     step_reg     <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                now_reg      <= now_ms;
                target_reg   <= t_next;
                actual_reg   <= a_next;
                deadline_reg <= dl_next;
                tvalid_reg   <= tv_next;
                dim_on_reg   <= dim_on_next;
                dim_up_reg   <= dim_up_next;
                wrote_reg    <= wrote_next;
                gamma_reg    <= wrote_next && (a_next != 8'd0) && (a_next < scale);
                if (cmd_t'(command) == CMD_TICK && tick_ok)
                    last_tick_reg <= now_ms;
                if (wrote_next)
                begin
                    if (a_next == 8'd0)
                        duty_reg <= 8'd0;
                    else if (a_next >= scale)
                        duty_reg <= 8'd255;
                end
            end
            if (cmd.div_start)
            begin
                quo_reg <= {actual_reg, {B{1'b0}}};
                rem_reg <= '0;
            end
            if (cmd.div_step)
            begin
                // restoring divide, one quotient bit a cycle
                if (rem_sh >= {1'b0, scale})
                begin
                    rem_reg <= rem_sh - {1'b0, scale};
                    quo_reg <= {quo_reg[QN-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[QN-2:0], 1'b0};
                end
            end
            if (cmd.finish)
            begin
                duty_reg <= gamma_rom[quo_reg[B-1:0]];
                if (!tvalid_reg)
                begin
                    tvalid_reg   <= (defoff_reg != 16'd0);
                    deadline_reg <= (defoff_reg != 16'd0) ?
                                    now_reg + 32'(defoff_reg) * 32'd1000 : 32'd0;
                end
            end
        end
    end

    assign duty_written  = wrote_reg;
    assign duty          = duty_reg;
    assign target_level  = target_reg;
    assign actual_level  = actual_reg;
    assign timer_running = tvalid_reg;
endmodule
